// ----- sv/bps_pkg.sv -----
`timescale 1ns / 1ps
package bps_pkg;

	// bytes held back before a decision is made, plus the head itself
	localparam int HOLD = 4;
	localparam int WIN  = HOLD + 1;
	localparam int FILL_W = $clog2(WIN + 1);

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_LETTER = 3'd1,
		KIND_NUMBER = 3'd2,
		KIND_SPACE  = 3'd3,
		KIND_PUNCT  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] digits;
		logic [1:0] contr_left;
		logic       pending;
		logic [1:0] tail_left;
	} run_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] len;
	} class_res_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_APOS  = 8'h27;

	function automatic logic in_rng(input logic [20:0] v, input logic [20:0] lo,
		input logic [20:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	// utf-8 decode of the character at b0 with rem bytes known, then classify
	function automatic class_res_t classify(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [FILL_W-1:0] rem);
		class_res_t r;
		logic [2:0]  n;
		logic [20:0] cp;
		logic        ok;
		r.len = 3'd1;
		r.kind = KIND_LETTER;
		n = 3'd1;
		cp = {13'd0, b0};
		if (b0 < 8'h80) begin
			if ((b0 >= 8'h61 && b0 <= 8'h7A) || (b0 >= 8'h41 && b0 <= 8'h5A))
				r.kind = KIND_LETTER;
			else if (b0 >= 8'h30 && b0 <= 8'h39)
				r.kind = KIND_NUMBER;
			else if (b0 == 8'h20 || b0 == 8'h09 || b0 == 8'h0A || b0 == 8'h0D)
				r.kind = KIND_SPACE;
			else
				r.kind = KIND_PUNCT;
		end else begin
			if (b0[7:5] == 3'b110)      n = 3'd2;
			else if (b0[7:4] == 4'hE)   n = 3'd3;
			else if (b0[7:3] == 5'h1E)  n = 3'd4;
			else                        n = 3'd1;
			if (FILL_W'(n) > rem) n = rem[2:0];
			ok = (n < 3'd2 || b1[7:6] == 2'b10) && (n < 3'd3 || b2[7:6] == 2'b10)
				&& (n < 3'd4 || b3[7:6] == 2'b10);
			if (!ok) n = 3'd1;
			case (n)
				3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
				3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
				3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
				default: cp = {13'd0, b0};
			endcase
			r.len = n;
			if (cp == 21'h00A0 || in_rng(cp, 21'h2000, 21'h200A) || cp == 21'h2028
				|| cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F || cp == 21'h3000)
				r.kind = KIND_SPACE;
			else if (in_rng(cp, 21'h0660, 21'h0669) || in_rng(cp, 21'h06F0, 21'h06F9)
				|| in_rng(cp, 21'h0966, 21'h096F) || in_rng(cp, 21'hFF10, 21'hFF19))
				r.kind = KIND_NUMBER;
			else if (in_rng(cp, 21'h2000, 21'h206F) || in_rng(cp, 21'h20A0, 21'h27BF)
				|| in_rng(cp, 21'h2E00, 21'h2E7F) || in_rng(cp, 21'h3000, 21'h303F)
				|| in_rng(cp, 21'hFE10, 21'hFE1F) || in_rng(cp, 21'hFE30, 21'hFE6F)
				|| in_rng(cp, 21'hFF00, 21'hFF0F) || in_rng(cp, 21'hFF1A, 21'hFF20)
				|| in_rng(cp, 21'hFF3B, 21'hFF40) || in_rng(cp, 21'hFF5B, 21'hFF65)
				|| in_rng(cp, 21'h1F000, 21'h1FAFF))
				r.kind = KIND_PUNCT;
			else
				r.kind = KIND_LETTER;
		end
		return r;
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	// contraction length at b0 (0, 2 or 3)
	function automatic logic [1:0] contraction(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [FILL_W-1:0] rem);
		logic [7:0] c1;
		logic [7:0] c2;
		logic [1:0] r;
		c1 = lower(b1);
		c2 = lower(b2);
		r = 2'd0;
		if (rem != '0 && b0 == CH_APOS) begin
			if (rem >= FILL_W'(3) && ((c1 == 8'h72 && c2 == 8'h65)
				|| (c1 == 8'h76 && c2 == 8'h65) || (c1 == 8'h6C && c2 == 8'h6C)))
				r = 2'd3;
			else if (rem >= FILL_W'(2) && (c1 == 8'h73 || c1 == 8'h64 || c1 == 8'h6D
				|| c1 == 8'h74))
				r = 2'd2;
		end
		return r;
	endfunction

endpackage

// ----- sv/bps_mark.sv -----
`timescale 1ns / 1ps
module bps_mark (
	input  logic [7:0]                 win [bps_pkg::WIN],
	input  logic [bps_pkg::FILL_W-1:0] fill,
	input  logic                       split_digits,
	input  bps_pkg::run_state_t        st,
	output logic                       mark,
	output bps_pkg::run_state_t        st_next
);
	import bps_pkg::*;

	class_res_t c0, c1;
	logic [1:0] k0, k1;
	logic [FILL_W-1:0] rem1;
	logic more, joins, do_open, do_space, space_first;

	// character and contraction lookups at the head and the next byte
	always_comb begin
		rem1 = (fill != '0) ? fill - FILL_W'(1) : '0;
		more = fill > FILL_W'(1);
		c0 = classify(win[0], win[1], win[2], win[3], fill);
		c1 = classify(win[1], win[2], win[3], win[4], rem1);
		k0 = contraction(win[0], win[1], win[2], fill);
		k1 = contraction(win[1], win[2], win[3], rem1);
		joins = more && !(split_digits && c1.kind == KIND_NUMBER) && (k1 == 2'd0);
	end

	// run state update for the head byte
	always_comb begin
		st_next = st;
		mark = 1'b0;
		do_open = 1'b0;
		do_space = 1'b0;
		space_first = 1'b0;
		if (st.contr_left != 2'd0) begin
			st_next.contr_left = st.contr_left - 2'd1;
		end else if (st.tail_left != 2'd0) begin
			st_next.tail_left = st.tail_left - 2'd1;
		end else if (st.pending) begin
			do_space = 1'b1;
		end else if (st.kind == KIND_NONE) begin
			do_open = 1'b1;
		end else if (st.kind == KIND_NUMBER && (split_digits || st.digits == 2'd3)) begin
			do_open = 1'b1;
		end else if (c0.kind != st.kind) begin
			do_open = 1'b1;
		end else begin
			st_next.tail_left = c0.len[1:0] - 2'd1;
			if (c0.kind == KIND_NUMBER) st_next.digits = st.digits + 2'd1;
		end
		if (do_open) begin
			if (k0 != 2'd0) begin
				st_next.contr_left = k0 - 2'd1;
				st_next.kind = KIND_NONE;
				mark = 1'b1;
			end else if (win[0] == CH_SPACE) begin
				do_space = 1'b1;
				space_first = 1'b1;
			end else begin
				st_next.kind = c0.kind;
				st_next.tail_left = c0.len[1:0] - 2'd1;
				st_next.digits = (c0.kind == KIND_NUMBER) ? 2'd1 : 2'd0;
				mark = 1'b1;
			end
		end
		if (do_space) begin
			if (more && win[1] == CH_SPACE) begin
				st_next.pending = 1'b1;
				st_next.kind = KIND_NONE;
				mark = space_first;
			end else begin
				st_next.pending = 1'b0;
				if (!joins) begin
					st_next.kind = KIND_NONE;
					mark = space_first;
				end else begin
					st_next.kind = c1.kind;
					st_next.digits = 2'd0;
					mark = 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/bytelevel_pretokenizer_splitter.sv -----
`timescale 1ns / 1ps
// Marks GPT-2 style pre-token piece starts on a stream of UTF-8 bytes. Bytes come
// out in input order, each with piece_start; a byte is released once four later
// bytes of the segment are held (or the segment ends), so output trails input by
// four items. In the steady state with no output stall, one item is taken and one
// released every cycle; the head decision is combinational logic over a five-byte
// window between the window and output registers. After an item with tlast the input
// stalls while up to five held bytes drain, one per cycle unless the output stalls.
module bytelevel_pretokenizer_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // text_byte
	input  logic       s_axis_tlast,   // seg_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tuser,   // piece_start
	output logic       m_axis_tlast,   // seg_end
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data        // split_digits
);
	import bps_pkg::*;

	logic [7:0]        win_q [WIN];
	logic [FILL_W-1:0] fill_q;
	logic              flush_q;
	logic              split_q;
	run_state_t        st_q, st_next;
	logic              mark, out_free, pop, accept, seg_done;
	logic [FILL_W-1:0] wr_pos;

	bps_mark u_mark (
		.win(win_q), .fill(fill_q), .split_digits(split_q), .st(st_q),
		.mark(mark), .st_next(st_next)
	);

	// handshake control
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign pop = out_free && fill_q != '0 && (fill_q == FILL_W'(WIN) || flush_q);
	assign seg_done = pop && flush_q && fill_q == FILL_W'(1);
	assign s_axis_tready = !flush_q && (fill_q != FILL_W'(WIN) || pop);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign wr_pos = pop ? fill_q - FILL_W'(1) : fill_q;
	assign cfg_ready = 1'b1;

	// window shift and append
	always_ff @(posedge clk) begin
		for (int i = 0; i < WIN; i++) begin
			if (accept && wr_pos == FILL_W'(i))
				win_q[i] <= s_axis_tdata;
			else if (pop && i < WIN - 1)
				win_q[i] <= win_q[(i < WIN - 1) ? i + 1 : i];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			flush_q <= 1'b0;
			split_q <= 1'b0;
			st_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			fill_q <= fill_q - FILL_W'(pop) + FILL_W'(accept);
			if (accept && s_axis_tlast) flush_q <= 1'b1;
			else if (seg_done) flush_q <= 1'b0;
			if (cfg_valid) split_q <= cfg_data;
			if (seg_done) st_q <= '0;
			else if (pop) st_q <= st_next;
			m_axis_tvalid <= pop || (m_axis_tvalid && !m_axis_tready);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (pop) begin
			m_axis_tdata <= win_q[0];
			m_axis_tuser <= mark;
			m_axis_tlast <= seg_done;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN)) else $error("window overfilled");
	a_flush_stall: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !s_axis_tready) else $error("input taken during drain");
	a_seg_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seg_done |=> fill_q == '0 && !flush_q) else $error("window not empty after segment");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != '0) else $error("release from empty window");

endmodule

// ----- test/tb_bytelevel_pretokenizer_splitter.sv -----
`timescale 1ns / 1ps
module tb_bytelevel_pretokenizer_splitter;
	import bps_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       last;
	} piece_byte_t;

	// piece marker, kept in step with the accepted items
	class piece_scoreboard;
		logic [7:0]  win[$];
		kind_t       kind;
		int unsigned digits, contr_left, tail_left;
		bit          pending, split;
		piece_byte_t marked_q[$];
		int          errors;

		function void clear_runs();
			kind = KIND_NONE;
			digits = 0;
			contr_left = 0;
			tail_left = 0;
			pending = 0;
		endfunction

		function kind_t kind_at(int p, output int len);
			int rem, n;
			logic [7:0] b, c;
			logic [20:0] cp;
			rem = win.size() - p;
			b = win[p];
			len = 1;
			if (b < 8'h80) begin
				if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return KIND_LETTER;
				if (b >= "0" && b <= "9") return KIND_NUMBER;
				if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) return KIND_SPACE;
				return KIND_PUNCT;
			end
			if (b[7:5] == 3'b110) n = 2;
			else if (b[7:4] == 4'hE) n = 3;
			else if (b[7:3] == 5'h1E) n = 4;
			else n = 1;
			if (n > rem) n = rem;
			cp = {13'd0, b};
			if (n > 1) begin
				cp = {13'd0, b} & ((21'd1 << (7 - n)) - 21'd1);
				for (int i = 1; i < n; i++) begin
					c = win[p + i];
					if (c[7:6] != 2'b10) begin
						n = 1;
						cp = {13'd0, b};
						break;
					end
					cp = (cp << 6) | c[5:0];
				end
			end
			len = n;
			if (cp == 'hA0 || (cp >= 'h2000 && cp <= 'h200A) || cp == 'h2028 || cp == 'h2029
				|| cp == 'h202F || cp == 'h205F || cp == 'h3000) return KIND_SPACE;
			if ((cp >= 'h660 && cp <= 'h669) || (cp >= 'h6F0 && cp <= 'h6F9)
				|| (cp >= 'h966 && cp <= 'h96F) || (cp >= 'hFF10 && cp <= 'hFF19))
				return KIND_NUMBER;
			if ((cp >= 'h2000 && cp <= 'h206F) || (cp >= 'h20A0 && cp <= 'h27BF)
				|| (cp >= 'h2E00 && cp <= 'h2E7F) || (cp >= 'h3000 && cp <= 'h303F)
				|| (cp >= 'hFE10 && cp <= 'hFE1F) || (cp >= 'hFE30 && cp <= 'hFE6F)
				|| (cp >= 'hFF00 && cp <= 'hFF0F) || (cp >= 'hFF1A && cp <= 'hFF20)
				|| (cp >= 'hFF3B && cp <= 'hFF40) || (cp >= 'hFF5B && cp <= 'hFF65)
				|| (cp >= 'h1F000 && cp <= 'h1FAFF)) return KIND_PUNCT;
			return KIND_LETTER;
		endfunction

		function logic [7:0] lc(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function int contr_len(int p);
			int rem;
			logic [7:0] c1, c2;
			if (p >= win.size() || win[p] != CH_APOS) return 0;
			rem = win.size() - p;
			c1 = rem >= 2 ? lc(win[p + 1]) : 8'h00;
			c2 = rem >= 3 ? lc(win[p + 2]) : 8'h00;
			if (rem >= 3 && ((c1 == "r" && c2 == "e") || (c1 == "v" && c2 == "e")
				|| (c1 == "l" && c2 == "l"))) return 3;
			if (rem >= 2 && (c1 == "s" || c1 == "d" || c1 == "m" || c1 == "t")) return 2;
			return 0;
		endfunction

		function bit space_mark(bit first);
			int len;
			bit joins;
			if (win.size() > 1 && win[1] == CH_SPACE) begin
				pending = 1;
				kind = KIND_NONE;
				return first;
			end
			pending = 0;
			joins = win.size() > 1 && !(split && kind_at(1, len) == KIND_NUMBER)
				&& contr_len(1) == 0;
			if (!joins) begin
				kind = KIND_NONE;
				return first;
			end
			kind = kind_at(1, len);
			digits = 0;
			return 1;
		endfunction

		function bit open_piece();
			int len, c;
			kind_t k;
			c = contr_len(0);
			if (c != 0) begin
				contr_left = c - 1;
				kind = KIND_NONE;
				return 1;
			end
			if (win[0] == CH_SPACE) return space_mark(1);
			k = kind_at(0, len);
			kind = k;
			tail_left = len - 1;
			digits = (k == KIND_NUMBER) ? 1 : 0;
			return 1;
		endfunction

		function bit head_mark();
			int len;
			kind_t k;
			if (contr_left != 0) begin
				contr_left--;
				return 0;
			end
			if (tail_left != 0) begin
				tail_left--;
				return 0;
			end
			if (pending) return space_mark(0);
			if (kind == KIND_NONE) return open_piece();
			if (kind == KIND_NUMBER && (split || digits >= 3)) return open_piece();
			k = kind_at(0, len);
			if (k != kind) return open_piece();
			tail_left = len - 1;
			if (k == KIND_NUMBER) digits++;
			return 0;
		endfunction

		// note an accepted input item, queueing every byte it releases
		function void note_item(logic [7:0] b, bit last);
			piece_byte_t e;
			win = {win, b};
			while (win.size() > 0 && (last || win.size() > HOLD)) begin
				e.data = win[0];
				e.start = head_mark();
				void'(win.pop_front());
				e.last = last && win.size() == 0;
				marked_q = {marked_q, e};
			end
			if (last) clear_runs();
		endfunction

		function void check_item(logic [7:0] d, logic s, logic l);
			piece_byte_t e;
			if (marked_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item %h %b %b", d, s, l);
				return;
			end
			e = marked_q.pop_front();
			if (d !== e.data || s !== e.start || l !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h/%b/%b got %h/%b/%b",
						e.data, e.start, e.last, d, s, l);
			end
		endfunction
	endclass

	logic       clk = 0, arst_n = 0;
	logic       s_axis_tvalid = 0, s_axis_tlast = 0;
	logic [7:0] s_axis_tdata = 0;
	logic       s_axis_tready;
	logic       m_axis_tvalid, m_axis_tuser, m_axis_tlast;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tready = 0;
	logic       cfg_valid = 0, cfg_data = 0;
	logic       cfg_ready;
	piece_scoreboard sb;

	bytelevel_pretokenizer_splitter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// valid stays high after the item so the next one can follow at once
	task automatic send_item(logic [7:0] b, bit last);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(b, last);
		@(negedge clk);
	endtask

	task automatic send_text(string txt, bit last);
		for (int i = 0; i < txt.len(); i++) send_item(txt[i], last && i == txt.len() - 1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.marked_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_split(bit v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.split = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// one random character of a chosen class
	task automatic send_char();
		logic [20:0] cp;
		case ($urandom_range(0, 12))
			0, 1: send_item(8'($urandom_range("a", "z")), 0);
			2: send_item(8'($urandom_range("0", "9")), 0);
			3, 4: send_item(CH_SPACE, 0);
			5: send_item(8'($urandom_range(8'h21, 8'h2F)), 0);
			6: send_text("'s", 0);
			7: send_text($urandom_range(0, 1) ? "'LL" : "'ve", 0);
			8: begin
				send_item(8'hD9, 0);
				send_item(8'(8'hA0 + $urandom_range(0, 9)), 0);
			end
			9: begin
				cp = 21'($urandom_range(0, 1) ? 21'h3000 : 21'hFF10 + $urandom_range(0, 12));
				send_item({4'hE, cp[15:12]}, 0);
				send_item({2'b10, cp[11:6]}, 0);
				send_item({2'b10, cp[5:0]}, 0);
			end
			10: begin
				cp = 21'(21'h1F600 + $urandom_range(0, 255));
				send_item({5'h1E, cp[20:18]}, 0);
				send_item({2'b10, cp[17:12]}, 0);
				send_item({2'b10, cp[11:6]}, 0);
				send_item({2'b10, cp[5:0]}, 0);
			end
			default: send_item(8'($urandom_range(0, 255)), 0);
		endcase
	endtask

	// result side: random stalls
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(5, 30)) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 9) < 7) ? 1 : ($urandom_range(0, 19) == 0);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);

	initial begin
		sb = new();
		sb.clear_runs();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: contractions, spaces, digits, utf-8 edge cases
		send_text("It's  we'RE 12345 ", 1);
		drain();
		write_split(1);
		send_text(" 12 'd", 0);
		send_item(8'hFF, 0);
		send_item(8'h00, 0);
		send_item(8'hC2, 0);
		send_item(8'hA0, 0);
		send_item(8'hE3, 1);
		drain();
		write_split(0);
		for (int seg = 0; seg < 40; seg++) begin
			int n;
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) send_char();
			send_item(8'($urandom_range(0, 1) ? 8'h80 + $urandom_range(0, 127)
				: $urandom_range(0, 127)), 1);
			if (seg % 10 == 9) begin
				drain();
				write_split(1'($urandom_range(0, 1)));
			end
		end
		drain();
		write_split(1);
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.marked_q.size() == 0)
			$display("** bytelevel_pretokenizer_splitter: PASSED **");
		else
			$display("** bytelevel_pretokenizer_splitter: FAILED **");
		$finish;
	end

	initial begin
		#2ms;
		$display("** bytelevel_pretokenizer_splitter: FAILED **");
		$finish;
	end
endmodule
